// ===== hdl/planar_span_fill_top_macros.svh =====
// ----------------------------------------------------------------------------
// Span fill assertion macros
// Concurrent assertion helpers used by the span fill top level.
// ----------------------------------------------------------------------------
`ifndef PLANAR_SPAN_FILL_TOP_MACROS_SVH
`define PLANAR_SPAN_FILL_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define PSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define PSF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSF_ASSERT(lbl, prop, msg)
`define PSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// Span fill package
// Geometry constants and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

	// Frame geometry.
	localparam int GROUPS_PER_ROW = 20;
	localparam int SCREEN_ROWS    = 200;

	// Field widths.
	localparam int XW    = 9;
	localparam int ROWW  = 8;
	localparam int COLW  = 4;
	localparam int BASEW = 21;
	localparam int ADDRW = 22;
	localparam int MASKW = 16;
	localparam int GW    = XW - 4;

	// Last pixel column of a row, held to the range of the column field.
	localparam int XLIM_INT = GROUPS_PER_ROW * 16 - 1;
	localparam logic [XW-1:0] X_LIMIT =
		(XLIM_INT > (1 << XW) - 1) ? {XW{1'b1}} : XW'(XLIM_INT);

	// Last screen row, held to the range of the row field.
	localparam logic [ROWW-1:0] ROW_LIMIT =
		(SCREEN_ROWS - 1 > (1 << ROWW) - 1) ? {ROWW{1'b1}} : ROWW'(SCREEN_ROWS - 1);

	// Row pitch in groups, as a multiplier operand.
	localparam logic [7:0] ROW_PITCH = 8'(GROUPS_PER_ROW);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_group;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/psf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Span fill controller
// Sequences one span request: capture, address setup, then one write per
// group until the datapath flags the final group.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  psf_pkg::sts_t  sts,
	output psf_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   setup_q;
	logic   emit_q;

	// State and registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			setup_q <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
						busy_q  <= 1'b1;
						setup_q <= 1'b1;
					end
				end
				ST_SETUP: begin
					state_q <= ST_RUN;
					setup_q <= 1'b0;
					emit_q  <= 1'b1;
				end
				ST_RUN: begin
					if (sts.final_group) begin
						state_q <= ST_IDLE;
						emit_q  <= 1'b0;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					setup_q <= 1'b0;
					emit_q  <= 1'b0;
				end
			endcase
		end
	end

	// A request is taken whenever the block is free.
	assign cmd.load  = start && !busy_q;
	assign cmd.setup = setup_q;
	assign cmd.emit  = emit_q;
	assign busy      = busy_q;

endmodule

`default_nettype wire

// ===== hdl/psf_datapath.sv =====
// ----------------------------------------------------------------------------
// Span fill datapath
// Holds the span, the frame base and the group counter, and builds the
// registered write for each group of the span.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  psf_pkg::cmd_t                cmd,
	output psf_pkg::sts_t                sts,
	input  wire                          cfg_wr_en,
	input  wire [psf_pkg::BASEW-1:0]     cfg_wr_data,
	input  wire [psf_pkg::XW-1:0]        x_start,
	input  wire [psf_pkg::XW-1:0]        x_end,
	input  wire [psf_pkg::ROWW-1:0]      row,
	input  wire [psf_pkg::COLW-1:0]      color,
	output logic                         result_strobe,
	output logic [psf_pkg::ADDRW-1:0]    group_address,
	output logic [psf_pkg::MASKW-1:0]    pixel_mask,
	output logic [psf_pkg::MASKW-1:0]    plane_zero,
	output logic [psf_pkg::MASKW-1:0]    plane_one,
	output logic [psf_pkg::MASKW-1:0]    plane_two,
	output logic [psf_pkg::MASKW-1:0]    plane_three,
	output logic                         last
);

	logic [psf_pkg::BASEW-1:0] frame_base_q;
	logic [psf_pkg::XW-1:0]    xs_q;
	logic [psf_pkg::XW-1:0]    xe_q;
	logic [psf_pkg::ROWW-1:0]  row_q;
	logic [psf_pkg::COLW-1:0]  color_q;
	logic [psf_pkg::ADDRW-1:0] base_q;
	logic [psf_pkg::GW-1:0]    g_q;
	logic                      strobe_q;

	logic [psf_pkg::GW-1:0]    sg;
	logic [psf_pkg::GW-1:0]    eg;
	logic [psf_pkg::MASKW-1:0] smask;
	logic [psf_pkg::MASKW-1:0] emask;
	logic [psf_pkg::MASKW-1:0] mask;
	logic [15:0]               row_offset;
	logic                      reversed;

	// Frame base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q <= '0;
		end else if (cfg_wr_en) begin
			frame_base_q <= cfg_wr_data;
		end
	end

	// Capture the span with columns and row held inside the frame.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q    <= (x_start > psf_pkg::X_LIMIT) ? psf_pkg::X_LIMIT : x_start;
			xe_q    <= (x_end > psf_pkg::X_LIMIT) ? psf_pkg::X_LIMIT : x_end;
			row_q   <= (row > psf_pkg::ROW_LIMIT) ? psf_pkg::ROW_LIMIT : row;
			color_q <= color;
		end
	end

	// Group columns and edge masks of the span.
	assign sg         = xs_q[psf_pkg::XW-1:4];
	assign eg         = xe_q[psf_pkg::XW-1:4];
	assign smask      = 16'hFFFF >> xs_q[3:0];
	assign emask      = 16'hFFFF << (4'd15 - xe_q[3:0]);
	assign reversed   = eg < sg;
	assign row_offset = 16'(row_q) * 16'(psf_pkg::ROW_PITCH);

	// Mask of the current group.
	always_comb begin
		if (reversed) begin
			mask = '0;
		end else if (sg == eg) begin
			mask = smask & emask;
		end else if (g_q == sg) begin
			mask = smask;
		end else if (g_q == eg) begin
			mask = emask;
		end else begin
			mask = '1;
		end
	end

	// The walk ends on the end group, or at once on a reversed span.
	assign sts.final_group = reversed || (g_q == eg);

	// Row base address and group counter.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			base_q <= psf_pkg::ADDRW'(frame_base_q) + psf_pkg::ADDRW'(row_offset);
			g_q    <= sg;
		end else if (cmd.emit) begin
			g_q    <= g_q + 1'b1;
		end
	end

	// Write strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	// Registered write payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			group_address <= base_q + psf_pkg::ADDRW'(g_q);
			pixel_mask    <= mask;
			plane_zero    <= {psf_pkg::MASKW{color_q[0]}};
			plane_one     <= {psf_pkg::MASKW{color_q[1]}};
			plane_two     <= {psf_pkg::MASKW{color_q[2]}};
			plane_three   <= {psf_pkg::MASKW{color_q[3]}};
			last          <= sts.final_group;
		end
	end

	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

// ===== hdl/planar_span_fill_top.sv =====
// ----------------------------------------------------------------------------
// Planar span fill
// Turns one row span into masked writes over four interleaved bitplanes.
// ----------------------------------------------------------------------------
// A span request is taken when start is high and busy is low. The block then
// issues one write per 16-pixel group, left to right, each shown for a single
// cycle with result_strobe high; the receiver must take every write as it
// comes, since it cannot stall the block. A reversed span gives one write.
// A request passes through capture, then forming the row base address
// through the row pitch multiplier, then one write per group from the group
// counter. The write with last high closes the span, and busy is already low
// in that cycle. The user must write frame_base only while busy is low; the
// block itself does not enforce this.
`default_nettype none
`include "planar_span_fill_top_macros.svh"

module planar_span_fill_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [psf_pkg::BASEW-1:0]     cfg_wr_data,
	input  wire                          start,
	output logic                         busy,
	input  wire [psf_pkg::XW-1:0]        x_start,
	input  wire [psf_pkg::XW-1:0]        x_end,
	input  wire [psf_pkg::ROWW-1:0]      row,
	input  wire [psf_pkg::COLW-1:0]      color,
	output logic                         result_strobe,
	output logic [psf_pkg::ADDRW-1:0]    group_address,
	output logic [psf_pkg::MASKW-1:0]    pixel_mask,
	output logic [psf_pkg::MASKW-1:0]    plane_zero,
	output logic [psf_pkg::MASKW-1:0]    plane_one,
	output logic [psf_pkg::MASKW-1:0]    plane_two,
	output logic [psf_pkg::MASKW-1:0]    plane_three,
	output logic                         last
);

	psf_pkg::cmd_t cmd;
	psf_pkg::sts_t sts;

	// Sequencer.
	psf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Address, mask and plane data.
	psf_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.x_start       (x_start),
		.x_end         (x_end),
		.row           (row),
		.color         (color),
		.result_strobe (result_strobe),
		.group_address (group_address),
		.pixel_mask    (pixel_mask),
		.plane_zero    (plane_zero),
		.plane_one     (plane_one),
		.plane_two     (plane_two),
		.plane_three   (plane_three),
		.last          (last)
	);

	// The writes of one span come in consecutive cycles.
	`PSF_ASSERT(a_span_contiguous, result_strobe && !last |=> result_strobe, "span writes broke off before the last one")
	// The closing write coincides with the block being free again.
	`PSF_ASSERT(a_last_frees, result_strobe && last |-> !busy, "block still busy on the last write")
	// An accepted request makes the block busy in the next cycle.
	`PSF_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
	// Writes are only issued while a span is in progress.
	`PSF_ASSERT_ALWAYS(a_emit_in_span, cmd.emit |-> busy, "write issued outside a span")

endmodule

`default_nettype wire
